/* rtl/tmsa_pkg.sv */
`default_nettype none

package tmsa_pkg;

	// field and register widths
	localparam int COL_W       = 14;
	localparam int ROW_W       = 14;
	localparam int SIDX_W      = 28;
	localparam int OFF_W       = 32;
	localparam int DIM_W       = 15;
	localparam int PITCH_W     = 19;
	localparam int CODE_W      = 3;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 19;

	// largest image side accepted, in pixels or blocks as written
	localparam int MAX_DIM = 16384;

	// internal widths
	localparam int IDX_W   = 24;              // swizzled element index
	localparam int FWD_W   = IDX_W + 4;       // index scaled by up to 16 bytes
	localparam int DX_W    = 10;              // column pulled from a swizzle index
	localparam int DY_W    = 20;              // row pulled from a swizzle index
	localparam int PROD_W  = DY_W + PITCH_W;  // row times pitch
	localparam int SUM_W   = PROD_W + 1;      // full linear offset
	localparam int LIMIT_W = 2 * DIM_W + 4;   // image bytes

	// configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_DIRECTION,
		REG_ELEMENT_SIZE,
		REG_BLOCK_COMP,
		REG_IMAGE_WIDTH,
		REG_IMAGE_HEIGHT,
		REG_ROW_PITCH
	} cfg_reg_t;

	// interleave masks: 0xAA0F, 0xAA8F, 0xAACF
	typedef enum logic [1:0] {
		MASK_BYTE1,
		MASK_BYTE2_4,
		MASK_BYTE8_16
	} mask_sel_t;

	typedef struct packed {
		logic                 direction;
		logic [CODE_W-1:0]    code;
		mask_sel_t            mask_sel;
		logic [PITCH_W-1:0]   row_pitch;
		logic [LIMIT_W-1:0]   limit;
		logic                 oversize;
	} tmsa_cfg_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} tmsa_stage_en_t;

	// column bits onto the set bits of the mask
	function automatic logic [IDX_W-1:0] deposit_column(input logic [COL_W-1:0] c,
			input mask_sel_t sel);
		logic [IDX_W-1:0] r;
		r = '0;
		r[3:0] = c[3:0];
		case (sel)
			MASK_BYTE1: begin
				r[9] = c[4]; r[11] = c[5]; r[13] = c[6]; r[15] = c[7];
			end
			MASK_BYTE2_4: begin
				r[7] = c[4]; r[9] = c[5]; r[11] = c[6]; r[13] = c[7]; r[15] = c[8];
			end
			default: begin
				r[6] = c[4]; r[7] = c[5]; r[9] = c[6]; r[11] = c[7];
				r[13] = c[8]; r[15] = c[9];
			end
		endcase
		return r;
	endfunction

	// row bits onto the clear bits of the 32-bit mask
	function automatic logic [IDX_W-1:0] deposit_row(input logic [ROW_W-1:0] w,
			input mask_sel_t sel);
		logic [IDX_W-1:0] r;
		r = '0;
		case (sel)
			MASK_BYTE1: begin
				r[8:4] = w[4:0]; r[10] = w[5]; r[12] = w[6]; r[14] = w[7];
				r[21:16] = w[13:8];
			end
			MASK_BYTE2_4: begin
				r[6:4] = w[2:0]; r[8] = w[3]; r[10] = w[4]; r[12] = w[5];
				r[14] = w[6]; r[22:16] = w[13:7];
			end
			default: begin
				r[5:4] = w[1:0]; r[8] = w[2]; r[10] = w[3]; r[12] = w[4];
				r[14] = w[5]; r[23:16] = w[13:6];
			end
		endcase
		return r;
	endfunction

	function automatic logic [DX_W-1:0] extract_column(input logic [SIDX_W-1:0] s,
			input mask_sel_t sel);
		logic [DX_W-1:0] r;
		case (sel)
			MASK_BYTE1:   r = {2'b00, s[15], s[13], s[11], s[9], s[3:0]};
			MASK_BYTE2_4: r = {1'b0, s[15], s[13], s[11], s[9], s[7], s[3:0]};
			default:      r = {s[15], s[13], s[11], s[9], s[7], s[6], s[3:0]};
		endcase
		return r;
	endfunction

	function automatic logic [DY_W-1:0] extract_row(input logic [SIDX_W-1:0] s,
			input mask_sel_t sel);
		logic [DY_W-1:0] r;
		case (sel)
			MASK_BYTE1:   r = {s[27:16], s[14], s[12], s[10], s[8:4]};
			MASK_BYTE2_4: r = {1'b0, s[27:16], s[14], s[12], s[10], s[8], s[6:4]};
			default:      r = {2'b00, s[27:16], s[14], s[12], s[10], s[8], s[5:4]};
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/tiled_morton_swizzle_address_2d_core.sv */
`default_nettype none

// Standard-swizzle address generator for 2D images. In forward mode
// (direction 0) each request's column and row are interleaved on the size's
// mask and scaled to a swizzled byte offset; in inverse mode (direction 1)
// the swizzle index is split back into column and row and turned into
// row * row_pitch + column * element bytes. Offsets at or past the image's
// byte size, or any image side above 16384, give status 1 with offset 0.
// Throughput is one request per clock while res_stall is low; a request
// passes the input register, deposit/extract plus the row-pitch multiply,
// then the add and limit compare into the result register. The pipeline
// stalls only the stages that are full, so bubbles are squeezed out while
// a result waits. Configuration writes are always taken (cfg_ready is tied
// high) and must only be issued with the pipeline empty; derived settings
// settle in the cycle after the write.

module tiled_morton_swizzle_address_2d_core (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// configuration
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [tmsa_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [tmsa_pkg::CFG_DATA_W-1:0]      cfg_data,
	// request
	input  wire logic                                 req_valid,
	output logic                                      req_stall,
	input  wire logic [tmsa_pkg::COL_W-1:0]           column,
	input  wire logic [tmsa_pkg::ROW_W-1:0]           row_index,
	input  wire logic [tmsa_pkg::SIDX_W-1:0]          swizzle_index,
	// result
	output logic                                      res_valid,
	input  wire logic                                 res_stall,
	output logic [tmsa_pkg::OFF_W-1:0]                byte_offset,
	output logic                                      status
);

	tmsa_pkg::tmsa_cfg_t      settings;
	tmsa_pkg::tmsa_stage_en_t en;

	logic valid_s1, valid_s2, valid_s3;

	tmsa_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.settings  (settings)
	);

	// a stage moves when it is empty or the stage after it moves
	always_comb begin
		en.s3 = !valid_s3 || !res_stall;
		en.s2 = !valid_s2 || en.s3;
		en.s1 = !valid_s1 || en.s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en.s1)
				valid_s1 <= req_valid;
			if (en.s2)
				valid_s2 <= valid_s1;
			if (en.s3)
				valid_s3 <= valid_s2;
		end
	end

	assign req_stall = !en.s1;
	assign res_valid = valid_s3;

	tmsa_addr u_addr (
		.clk           (clk),
		.en            (en),
		.settings      (settings),
		.column        (column),
		.row_index     (row_index),
		.swizzle_index (swizzle_index),
		.byte_offset   (byte_offset),
		.status        (status)
	);

endmodule

`default_nettype wire

/* rtl/tmsa_cfg.sv */
`default_nettype none

module tmsa_cfg (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [tmsa_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [tmsa_pkg::CFG_DATA_W-1:0]      cfg_data,
	output tmsa_pkg::tmsa_cfg_t                       settings
);

	localparam int DIM_W  = tmsa_pkg::DIM_W;
	localparam int CODE_W = tmsa_pkg::CODE_W;

	logic                         direction_q;
	logic [CODE_W-1:0]            element_size_q;
	logic                         block_compressed_q;
	logic [DIM_W-1:0]             image_width_q;
	logic [DIM_W-1:0]             image_height_q;
	logic [tmsa_pkg::PITCH_W-1:0] row_pitch_q;

	logic [CODE_W-1:0]            code;
	tmsa_pkg::mask_sel_t          mask_sel;
	logic                         comp;
	logic [DIM_W:0]               w_sum, h_sum;
	logic [DIM_W-1:0]             w_eff, h_eff;
	logic [2*DIM_W-1:0]           area;
	logic [tmsa_pkg::LIMIT_W-1:0] limit;
	logic                         oversize;
	tmsa_pkg::tmsa_cfg_t          settings_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q        <= 1'b0;
			element_size_q     <= 3'd2;
			block_compressed_q <= 1'b0;
			image_width_q      <= DIM_W'(1);
			image_height_q     <= DIM_W'(1);
			row_pitch_q        <= tmsa_pkg::PITCH_W'(4);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tmsa_pkg::REG_DIRECTION:    direction_q        <= cfg_data[0];
				tmsa_pkg::REG_ELEMENT_SIZE: element_size_q     <= cfg_data[CODE_W-1:0];
				tmsa_pkg::REG_BLOCK_COMP:   block_compressed_q <= cfg_data[0];
				tmsa_pkg::REG_IMAGE_WIDTH:  image_width_q      <= cfg_data[DIM_W-1:0];
				tmsa_pkg::REG_IMAGE_HEIGHT: image_height_q     <= cfg_data[DIM_W-1:0];
				tmsa_pkg::REG_ROW_PITCH:
					row_pitch_q <= cfg_data[tmsa_pkg::PITCH_W-1:0];
				default: ;
			endcase
		end
	end

	// undefined size codes behave as 4 bytes
	always_comb begin
		code = (element_size_q > 3'd4) ? 3'd2 : element_size_q;
		if (code == 3'd0)
			mask_sel = tmsa_pkg::MASK_BYTE1;
		else if (code <= 3'd2)
			mask_sel = tmsa_pkg::MASK_BYTE2_4;
		else
			mask_sel = tmsa_pkg::MASK_BYTE8_16;
		comp     = block_compressed_q && (code >= 3'd3);
		w_sum    = {1'b0, image_width_q} + (DIM_W+1)'(3);
		h_sum    = {1'b0, image_height_q} + (DIM_W+1)'(3);
		w_eff    = comp ? {1'b0, w_sum[DIM_W:2]} : image_width_q;
		h_eff    = comp ? {1'b0, h_sum[DIM_W:2]} : image_height_q;
		area     = w_eff * h_eff;
		limit    = {{(tmsa_pkg::LIMIT_W-2*DIM_W){1'b0}}, area} << code;
		oversize = (image_width_q > DIM_W'(tmsa_pkg::MAX_DIM))
			|| (image_height_q > DIM_W'(tmsa_pkg::MAX_DIM));
	end

	// derived settings, registered from the configuration registers
	always_ff @(posedge clk) begin
		settings_q.direction <= direction_q;
		settings_q.code      <= code;
		settings_q.mask_sel  <= mask_sel;
		settings_q.row_pitch <= row_pitch_q;
		settings_q.limit     <= limit;
		settings_q.oversize  <= oversize;
	end

	assign settings = settings_q;

endmodule

`default_nettype wire

/* rtl/tmsa_addr.sv */
`default_nettype none

module tmsa_addr (
	input  wire logic                           clk,
	input  wire tmsa_pkg::tmsa_stage_en_t       en,
	input  wire tmsa_pkg::tmsa_cfg_t            settings,
	input  wire logic [tmsa_pkg::COL_W-1:0]     column,
	input  wire logic [tmsa_pkg::ROW_W-1:0]     row_index,
	input  wire logic [tmsa_pkg::SIDX_W-1:0]    swizzle_index,
	output logic [tmsa_pkg::OFF_W-1:0]          byte_offset,
	output logic                                status
);

	localparam int FWD_W  = tmsa_pkg::FWD_W;
	localparam int PROD_W = tmsa_pkg::PROD_W;
	localparam int SUM_W  = tmsa_pkg::SUM_W;

	logic [tmsa_pkg::COL_W-1:0]  column_s1;
	logic [tmsa_pkg::ROW_W-1:0]  row_s1;
	logic [tmsa_pkg::SIDX_W-1:0] sidx_s1;

	logic [tmsa_pkg::IDX_W-1:0]  idx;
	logic [FWD_W-1:0]            fwd_off;
	logic [tmsa_pkg::DX_W-1:0]   dx;
	logic [tmsa_pkg::DY_W-1:0]   dy;
	logic [PROD_W-1:0]           row_term;
	logic [FWD_W-1:0]            col_term;

	logic [PROD_W-1:0]           row_term_s2;
	logic [FWD_W-1:0]            add_term_s2;

	logic [SUM_W-1:0]            sum;
	logic                        err;

	logic [tmsa_pkg::OFF_W-1:0]  byte_offset_s3;
	logic                        status_s3;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			column_s1 <= column;
			row_s1    <= row_index;
			sidx_s1   <= swizzle_index;
		end
	end

	// deposits are disjoint, so the sum is an OR
	always_comb begin
		idx = tmsa_pkg::deposit_column(column_s1, settings.mask_sel)
			| tmsa_pkg::deposit_row(row_s1, settings.mask_sel);
		fwd_off  = {{(FWD_W-tmsa_pkg::IDX_W){1'b0}}, idx} << settings.code;
		dx       = tmsa_pkg::extract_column(sidx_s1, settings.mask_sel);
		dy       = tmsa_pkg::extract_row(sidx_s1, settings.mask_sel);
		row_term = dy * settings.row_pitch;
		col_term = {{(FWD_W-tmsa_pkg::DX_W){1'b0}}, dx} << settings.code;
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			row_term_s2 <= settings.direction ? row_term : '0;
			add_term_s2 <= settings.direction ? col_term : fwd_off;
		end
	end

	always_comb begin
		sum = {1'b0, row_term_s2} + {{(SUM_W-FWD_W){1'b0}}, add_term_s2};
		err = settings.oversize
			|| (sum >= {{(SUM_W-tmsa_pkg::LIMIT_W){1'b0}}, settings.limit});
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			byte_offset_s3 <= err ? '0 : sum[tmsa_pkg::OFF_W-1:0];
			status_s3      <= err;
		end
	end

	assign byte_offset = byte_offset_s3;
	assign status      = status_s3;

endmodule

`default_nettype wire

/* tb/tiled_morton_swizzle_address_2d_core_tb.sv */
`default_nettype none

module tiled_morton_swizzle_address_2d_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// run shape
	localparam int N_PHASES    = 10;
	localparam int PHASE_ITEMS = 60;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 8;     // pipeline is three deep, leave margin
	localparam int HOLD_AT     = 100;   // result count that triggers the long hold-off
	localparam int HOLD_LEN    = 150;
	localparam int CALM_LO     = 300;   // result window with no idling on either side
	localparam int CALM_HI     = 400;

	localparam int CFG_INDEX_W = tmsa_pkg::CFG_INDEX_W;
	localparam int CFG_DATA_W  = tmsa_pkg::CFG_DATA_W;
	localparam int COL_W       = tmsa_pkg::COL_W;
	localparam int ROW_W       = tmsa_pkg::ROW_W;
	localparam int SIDX_W      = tmsa_pkg::SIDX_W;
	localparam int OFF_W       = tmsa_pkg::OFF_W;
	localparam int CODE_W      = tmsa_pkg::CODE_W;
	localparam int DIM_W       = tmsa_pkg::DIM_W;
	localparam int PITCH_W     = tmsa_pkg::PITCH_W;
	localparam int MAX_DIM     = tmsa_pkg::MAX_DIM;

	// interleave masks, spread over 32 bits
	localparam logic [31:0] MASK_1B    = 32'h0000_AA0F;
	localparam logic [31:0] MASK_2B_4B = 32'h0000_AA8F;
	localparam logic [31:0] MASK_8B_16B = 32'h0000_AACF;

	localparam logic ST_OK    = 1'b0;
	localparam logic ST_RANGE = 1'b1;

	typedef struct packed {
		logic               dir;
		logic [CODE_W-1:0]  esize;
		logic               comp;
		logic [DIM_W-1:0]   width;
		logic [DIM_W-1:0]   height;
		logic [PITCH_W-1:0] pitch;
	} img_cfg_t;

	typedef struct packed {
		logic [OFF_W-1:0] offset;
		logic             st;
	} addr_res_t;

	typedef struct packed {
		img_cfg_t          cfg;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic [SIDX_W-1:0] sidx;
		logic              typed;   // expectation given in the row itself
		addr_res_t         want;
	} stim_row_t;

	// DUT connections, all inputs known from time zero
	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   cfg_valid     = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index     = '0;
	logic [CFG_DATA_W-1:0]  cfg_data      = '0;
	logic                   req_valid     = 1'b0;
	logic                   req_stall;
	logic [COL_W-1:0]       column        = '0;
	logic [ROW_W-1:0]       row_index     = '0;
	logic [SIDX_W-1:0]      swizzle_index = '0;
	logic                   res_valid;
	logic                   res_stall     = 1'b0;
	logic [OFF_W-1:0]       byte_offset;
	logic                   status;

	// our copy of the register file, reset values
	img_cfg_t  cur_cfg = '{dir: 1'b0, esize: 3'd2, comp: 1'b0, width: 15'd1,
			height: 15'd1, pitch: 19'd4};

	addr_res_t addr_due_q[$];     // offsets still owed by the block, oldest first
	stim_row_t directed_rows[$];
	int        mismatches = 0;
	int        res_count  = 0;     // results taken, updated on the falling edge
	int        cycles     = 0;
	logic      calm_stretch;

	assign calm_stretch = (res_count >= CALM_LO) && (res_count < CALM_HI);

	tiled_morton_swizzle_address_2d_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.column        (column),
		.row_index     (row_index),
		.swizzle_index (swizzle_index),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.byte_offset   (byte_offset),
		.status        (status)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Address prediction
	// ------------------------------------------------------------------

	// low bits of v land on the set bits of m, in order
	function automatic logic [31:0] bit_deposit(input logic [31:0] v, input logic [31:0] m);
		logic [31:0] r;
		int          k;
		r = '0;
		k = 0;
		for (int i = 0; i < 32; i++) begin
			if (m[i]) begin
				r[i] = v[k];
				k++;
			end
		end
		return r;
	endfunction

	// set bits of m pulled out of v and packed from bit 0
	function automatic logic [31:0] bit_extract(input logic [31:0] v, input logic [31:0] m);
		logic [31:0] r;
		int          k;
		r = '0;
		k = 0;
		for (int i = 0; i < 32; i++) begin
			if (m[i]) begin
				r[k] = v[i];
				k++;
			end
		end
		return r;
	endfunction

	function automatic addr_res_t swizzle_addr_calc(input img_cfg_t c,
			input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
			input logic [SIDX_W-1:0] sidx);
		logic [CODE_W-1:0]   code;
		tmsa_pkg::mask_sel_t sel;
		logic [31:0]         m;
		logic [63:0]         bytes, w, h, limit, off, dx, dy;
		addr_res_t           r;
		// size codes past 16 bytes behave as 4 bytes
		code  = (c.esize > 3'd4) ? 3'd2 : c.esize;
		bytes = 64'd1 << code;
		sel   = (code == 3'd0) ? tmsa_pkg::MASK_BYTE1
			: ((code <= 3'd2) ? tmsa_pkg::MASK_BYTE2_4 : tmsa_pkg::MASK_BYTE8_16);
		case (sel)
			tmsa_pkg::MASK_BYTE1:   m = MASK_1B;
			tmsa_pkg::MASK_BYTE2_4: m = MASK_2B_4B;
			default:                m = MASK_8B_16B;
		endcase
		w = 64'(c.width);
		h = 64'(c.height);
		// 4x4 block rounding only for 8 and 16 byte elements
		if (c.comp && code >= 3'd3) begin
			w = (w + 3) / 4;
			h = (h + 3) / 4;
		end
		limit = w * h * bytes;
		if (!c.dir) begin
			off = (64'(bit_deposit(32'(col), m)) + 64'(bit_deposit(32'(row), ~m))) * bytes;
		end else begin
			dx  = 64'(bit_extract(32'(sidx), m));
			dy  = 64'(bit_extract(32'(sidx), ~m));
			off = dy * 64'(c.pitch) + dx * bytes;
		end
		if (c.width > MAX_DIM || c.height > MAX_DIM || off >= limit) begin
			r.offset = '0;
			r.st     = ST_RANGE;
		end else begin
			r.offset = off[31:0];
			r.st     = ST_OK;
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic img_cfg_t mk_cfg(input logic d, input int es, input logic cp,
			input int w, input int h, input int p);
		img_cfg_t c;
		c.dir    = d;
		c.esize  = es[CODE_W-1:0];
		c.comp   = cp;
		c.width  = w[DIM_W-1:0];
		c.height = h[DIM_W-1:0];
		c.pitch  = p[PITCH_W-1:0];
		return c;
	endfunction

	function automatic stim_row_t mk_row(input img_cfg_t c, input int col, input int row,
			input int sidx, input logic typed, input logic [OFF_W-1:0] off, input logic st);
		stim_row_t s;
		s.cfg         = c;
		s.col         = col[COL_W-1:0];
		s.row         = row[ROW_W-1:0];
		s.sidx        = sidx[SIDX_W-1:0];
		s.typed       = typed;
		s.want.offset = off;
		s.want.st     = st;
		return s;
	endfunction

	// image side: mostly sane sizes, now and then oversize or zero
	function automatic logic [DIM_W-1:0] rand_side();
		int v;
		case ($urandom_range(0, 19))
			0:                  v = 1;
			1:                  v = MAX_DIM;
			2, 3, 4, 5, 6, 7:   v = $urandom_range(1, 64);
			8, 9, 10, 11, 12:   v = $urandom_range(1, MAX_DIM);
			13, 14, 15, 16, 17: v = 1 << $urandom_range(0, 14);
			18:                 v = $urandom_range(MAX_DIM + 1, 32767);
			default:            v = 0;
		endcase
		return v[DIM_W-1:0];
	endfunction

	// Registers change only with the pipeline empty: stop offering, wait for the
	// last result, let the pipe settle, then write all six.
	task automatic load_settings(input img_cfg_t c);
		logic [CFG_DATA_W-1:0] v;
		tmsa_pkg::cfg_reg_t    r;
		req_valid <= 1'b0;
		while (addr_due_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		for (int i = 0; i <= int'(tmsa_pkg::REG_ROW_PITCH); i++) begin
			r = tmsa_pkg::cfg_reg_t'(i);
			case (r)
				tmsa_pkg::REG_DIRECTION:    v = CFG_DATA_W'(c.dir);
				tmsa_pkg::REG_ELEMENT_SIZE: v = CFG_DATA_W'(c.esize);
				tmsa_pkg::REG_BLOCK_COMP:   v = CFG_DATA_W'(c.comp);
				tmsa_pkg::REG_IMAGE_WIDTH:  v = CFG_DATA_W'(c.width);
				tmsa_pkg::REG_IMAGE_HEIGHT: v = CFG_DATA_W'(c.height);
				default:                    v = CFG_DATA_W'(c.pitch);
			endcase
			cfg_valid <= 1'b1;
			cfg_index <= r;
			cfg_data  <= v;
			@(negedge clk);
			while (!cfg_ready)
				@(negedge clk);
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		cur_cfg = c;
		// derived settings land in the cycle after the write
		repeat (2) @(posedge clk);
	endtask

	// Offer one request; returns on the edge that takes it. The expectation is
	// queued at that edge, from the row itself or from the predictor.
	task automatic send_request(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
			input logic [SIDX_W-1:0] sidx, input logic typed, input addr_res_t want);
		addr_res_t due;
		bit        lowered;
		lowered = 1'b0;
		while (!calm_stretch && $urandom_range(0, 99) < 31) begin
			if (!lowered) begin
				req_valid <= 1'b0;
				lowered = 1'b1;
			end
			@(posedge clk);
		end
		req_valid     <= 1'b1;
		column        <= col;
		row_index     <= row;
		swizzle_index <= sidx;
		@(negedge clk);
		while (req_stall)
			@(negedge clk);
		@(posedge clk);
		due = typed ? want : swizzle_addr_calc(cur_cfg, col, row, sidx);
		addr_due_q.push_back(due);
	endtask

	// ------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------

	// Sampled mid-cycle: valid and stall seen here are what the next rising
	// edge sees, so a transfer is counted without racing the DUT's update.
	always @(negedge clk) begin
		addr_res_t e;
		if (arst_n && res_valid && !res_stall) begin
			if (addr_due_q.size() == 0) begin
				$error("result with nothing outstanding: byte_offset %h status %b",
						byte_offset, status);
				mismatches++;
			end else begin
				e = addr_due_q.pop_front();
				if (byte_offset !== e.offset) begin
					$error("byte_offset: expected %h, got %h", e.offset, byte_offset);
					mismatches++;
				end
				if (status !== e.st) begin
					$error("status: expected %b, got %b", e.st, status);
					mismatches++;
				end
			end
			res_count++;
		end
	end

	// Receiver back-pressure: random stalls, one long hold-off counted here so
	// the pipe fills and pushes back on requests, and a calm window.
	initial begin
		int  hold_left;
		bit  hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else if (!hold_done && res_count >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_LEN - 1;
				res_stall <= 1'b1;
			end else begin
				res_stall <= !calm_stretch && ($urandom_range(0, 99) < 31);
			end
		end
	end

	// Watchdog
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		img_cfg_t          nc;
		logic [CODE_W-1:0] code;
		int unsigned       span_w, span_h, span_wh;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic [SIDX_W-1:0] sidx;

		// Directed table. Rows sharing a setting run back to back; a change of
		// setting drains the pipe and rewrites the registers.
		// after reset: 1x1 image of 4 byte elements
		directed_rows.push_back(mk_row(mk_cfg(0, 2, 0, 1, 1, 4), 0, 0, 0, 1, '0, ST_OK));
		directed_rows.push_back(mk_row(mk_cfg(0, 2, 0, 1, 1, 4), 1, 0, 0, 1, '0, ST_RANGE));
		directed_rows.push_back(mk_row(mk_cfg(0, 2, 0, 1, 1, 4), 16383, 16383, 'h0FFF_FFFF,
				1, '0, ST_RANGE));
		// forward, full size, 1 byte mask
		directed_rows.push_back(mk_row(mk_cfg(0, 0, 0, 16384, 16384, 4), 16383, 16383, 0,
				0, '0, ST_OK));
		directed_rows.push_back(mk_row(mk_cfg(0, 0, 0, 16384, 16384, 4), 0, 16383, 0,
				0, '0, ST_OK));
		// block compressed 8 bytes, then uncompressed 16 bytes
		directed_rows.push_back(mk_row(mk_cfg(0, 3, 1, 16384, 16384, 4), 16383, 16383, 0,
				0, '0, ST_OK));
		directed_rows.push_back(mk_row(mk_cfg(0, 3, 1, 16384, 16384, 4), 5, 7, 0,
				0, '0, ST_OK));
		directed_rows.push_back(mk_row(mk_cfg(0, 4, 0, 16384, 16384, 4), 16383, 16383, 0,
				0, '0, ST_OK));
		// undefined size codes fall back to 4 bytes, compression ignored
		directed_rows.push_back(mk_row(mk_cfg(0, 5, 1, 100, 100, 4), 3, 3, 0, 0, '0, ST_OK));
		directed_rows.push_back(mk_row(mk_cfg(0, 6, 1, 40, 40, 4), 2, 9, 0, 0, '0, ST_OK));
		directed_rows.push_back(mk_row(mk_cfg(0, 7, 0, 100, 100, 4), 10, 10, 0, 0, '0, ST_OK));
		// oversize side fails every request
		directed_rows.push_back(mk_row(mk_cfg(0, 2, 0, 16385, 16, 4), 0, 0, 0, 1, '0, ST_RANGE));
		directed_rows.push_back(mk_row(mk_cfg(0, 2, 0, 1, 32767, 4), 0, 0, 0, 1, '0, ST_RANGE));
		// zero width: no bytes at all
		directed_rows.push_back(mk_row(mk_cfg(0, 2, 0, 0, 100, 4), 0, 0, 0, 1, '0, ST_RANGE));
		// inverse mode
		directed_rows.push_back(mk_row(mk_cfg(1, 2, 0, 16384, 16384, 262144), 0, 0, 0,
				1, '0, ST_OK));
		directed_rows.push_back(mk_row(mk_cfg(1, 2, 0, 16384, 16384, 262144), 16383, 0,
				'h0FFF_FFFF, 0, '0, ST_OK));
		directed_rows.push_back(mk_row(mk_cfg(1, 4, 1, 16384, 16384, 524287), 0, 16383,
				'h0FFF_FFFF, 0, '0, ST_OK));
		// zero pitch: row term vanishes; the rows after it use a nonzero pitch
		directed_rows.push_back(mk_row(mk_cfg(1, 0, 0, 1000, 1000, 0), 0, 0, 'h0FFF_FFFF,
				0, '0, ST_OK));
		directed_rows.push_back(mk_row(mk_cfg(1, 0, 0, 1000, 1000, 0), 0, 0, 'h0555_5555,
				0, '0, ST_OK));
		directed_rows.push_back(mk_row(mk_cfg(1, 1, 0, 64, 64, 128), 0, 0, 'h0AAA_AAAA,
				0, '0, ST_OK));
		directed_rows.push_back(mk_row(mk_cfg(1, 1, 0, 64, 64, 128), 0, 0, 100, 0, '0, ST_OK));
		directed_rows.push_back(mk_row(mk_cfg(1, 3, 1, 30, 30, 64), 0, 0, 40, 0, '0, ST_OK));
		// column past the width is only judged by the final offset
		directed_rows.push_back(mk_row(mk_cfg(0, 1, 0, 1, 16384, 4), 0, 16383, 0, 0, '0, ST_OK));
		directed_rows.push_back(mk_row(mk_cfg(0, 1, 0, 1, 16384, 4), 5, 0, 0, 0, '0, ST_OK));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (directed_rows[k]) begin
			if (directed_rows[k].cfg != cur_cfg)
				load_settings(directed_rows[k].cfg);
			send_request(directed_rows[k].col, directed_rows[k].row, directed_rows[k].sidx,
					directed_rows[k].typed, directed_rows[k].want);
		end

		// Random phases: a fresh setting each, requests mostly inside the image
		// so the offsets land, the rest drawn over the full field widths.
		for (int ph = 0; ph < N_PHASES; ph++) begin
			nc.dir    = 1'($urandom_range(0, 1));
			nc.esize  = CODE_W'(($urandom_range(0, 9) < 8) ? $urandom_range(0, 4)
					: $urandom_range(5, 7));
			nc.comp   = 1'($urandom_range(0, 1));
			nc.width  = rand_side();
			nc.height = rand_side();
			code = (nc.esize > 3'd4) ? 3'd2 : nc.esize;
			case ($urandom_range(0, 9))
				0:          nc.pitch = '0;
				1:          nc.pitch = '1;
				2, 3, 4, 5: nc.pitch = PITCH_W'(32'(nc.width) << code);
				default:    nc.pitch = PITCH_W'($urandom());
			endcase
			load_settings(nc);

			span_w = 32'(nc.width);
			span_h = 32'(nc.height);
			if (nc.comp && code >= 3'd3) begin
				span_w = (span_w + 3) / 4;
				span_h = (span_h + 3) / 4;
			end
			if (span_w == 0) span_w = 1;
			if (span_h == 0) span_h = 1;
			if (span_w > MAX_DIM) span_w = MAX_DIM;
			if (span_h > MAX_DIM) span_h = MAX_DIM;
			span_wh = span_w * span_h;

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// one pause with the pipe run dry mid-phase
				if (ph == 4 && n == PHASE_ITEMS / 2) begin
					req_valid <= 1'b0;
					while (addr_due_q.size() != 0)
						@(posedge clk);
				end
				if ($urandom_range(0, 4) == 0) begin
					col  = COL_W'($urandom());
					row  = ROW_W'($urandom());
					sidx = SIDX_W'($urandom());
				end else begin
					col  = COL_W'($urandom_range(0, span_w - 1));
					row  = ROW_W'($urandom_range(0, span_h - 1));
					sidx = SIDX_W'($urandom_range(0, span_wh - 1));
				end
				send_request(col, row, sidx, 1'b0, '0);
			end
		end

		req_valid <= 1'b0;
		while (addr_due_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire

/* sim.f */
rtl/tmsa_pkg.sv
rtl/tmsa_cfg.sv
rtl/tmsa_addr.sv
rtl/tiled_morton_swizzle_address_2d_core.sv
tb/tiled_morton_swizzle_address_2d_core_tb.sv
